// ===== src/tdc_bfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// TDC buffer first-hit parser package
// Word type codes, field positions and widths shared by the parser RTL.
// ----------------------------------------------------------------------------
package tdc_bfhp_pkg;

	// Width of one buffer word and its type field.
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned KIND_W   = 5;

	// Result field widths.
	localparam int unsigned CHAN_W   = 5;
	localparam int unsigned TIME_W   = 21;
	localparam int unsigned EVENT_W  = 22;
	localparam int unsigned ERR_W    = 14;

	// Word type codes (bits 31:27).
	localparam logic [KIND_W-1:0] KIND_MEAS  = 5'h00;
	localparam logic [KIND_W-1:0] KIND_ERROR = 5'h04;
	localparam logic [KIND_W-1:0] KIND_GHEAD = 5'h08;
	localparam logic [KIND_W-1:0] KIND_OBTRL = 5'h10;
	localparam logic [KIND_W-1:0] KIND_FILL  = 5'h18;

	// Parser sequencer.
	typedef enum logic [1:0] {
		ST_ACCEPT = 2'b01,
		ST_DRAIN  = 2'b10
	} state_t;

endpackage

// ===== src/tdc_buffer_first_hit_parser.sv =====
// ----------------------------------------------------------------------------
// TDC buffer first-hit parser
// Decodes output buffer words and reports the first hit time per channel
// at the end of each block.
// ----------------------------------------------------------------------------
// Throughput: one buffer word per cycle while a block is being collected.
// A block end (buffer trailer, filler, or MAX_WORDS words) stalls the word
// input while the per-channel results drain, one per cycle unless the output
// stalls, through the single read port of the first-time memory.
// The first result of a block follows the ending word through the drain
// state, the memory read stage and the output register.
// Reset: asynchronous, active low; clears hit flags, event number, error
// flags, word count and control. The time memory is not cleared: entries are
// only used behind a set hit flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tdc_buffer_first_hit_parser #(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned MAX_WORDS    = 511
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Buffer word input
	input  logic                                word_valid,
	output logic                                word_stall,
	input  logic [tdc_bfhp_pkg::WORD_W-1:0]     word,

	// Per-channel result output
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [tdc_bfhp_pkg::CHAN_W-1:0]     channel,
	output logic                                hit,
	output logic [tdc_bfhp_pkg::TIME_W-1:0]     hit_time,
	output logic [tdc_bfhp_pkg::EVENT_W-1:0]    event_number,
	output logic [tdc_bfhp_pkg::ERR_W-1:0]      error_bits,
	output logic                                last
);

	localparam int unsigned CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned WORDS_W = $clog2(MAX_WORDS + 1);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	tdc_bfhp_pkg::state_t                 state_q;
	logic [NUM_CHANNELS-1:0]              hit_seen_q;
	logic [tdc_bfhp_pkg::EVENT_W-1:0]     event_q;
	logic [tdc_bfhp_pkg::ERR_W-1:0]       error_q;
	logic [WORDS_W-1:0]                   words_q;
	logic [CH_W-1:0]                      drain_ch_q;

	// First-time store: one 21-bit entry per channel, synchronous read.
	logic [tdc_bfhp_pkg::TIME_W-1:0]      first_time_mem [NUM_CHANNELS];

	// Read stage: channel in flight plus the block snapshot that goes with it.
	logic                                 valid_s1;
	logic [CH_W-1:0]                      ch_s1;
	logic                                 hit_s1;
	logic                                 last_s1;
	logic [tdc_bfhp_pkg::EVENT_W-1:0]     event_s1;
	logic [tdc_bfhp_pkg::ERR_W-1:0]       error_s1;
	logic [tdc_bfhp_pkg::TIME_W-1:0]      rd_data_s1;

	// Output register
	logic                                 result_valid_q;
	logic [tdc_bfhp_pkg::CHAN_W-1:0]      channel_q;
	logic                                 hit_q;
	logic [tdc_bfhp_pkg::TIME_W-1:0]      hit_time_q;
	logic [tdc_bfhp_pkg::EVENT_W-1:0]     event_number_q;
	logic [tdc_bfhp_pkg::ERR_W-1:0]       error_bits_q;
	logic                                 last_q;

	// ------------------------------------------------------------------
	// Word decode
	// ------------------------------------------------------------------
	logic                                 word_take;
	logic [tdc_bfhp_pkg::KIND_W-1:0]      kind;
	logic [tdc_bfhp_pkg::CHAN_W-1:0]      meas_ch;
	logic                                 meas_in_range;
	logic                                 mem_we;
	logic                                 end_kind;
	logic                                 end_limit;
	logic                                 block_end;

	// Drain control
	logic                                 out_free;
	logic                                 issue;
	logic                                 drain_last;

	// Words are taken only while collecting; the drain holds the input off.
	assign word_stall = (state_q == tdc_bfhp_pkg::ST_DRAIN);
	assign word_take  = word_valid && !word_stall;

	assign kind          = word[31:27];
	assign meas_ch       = word[25:21];
	assign meas_in_range = ({1'b0, meas_ch} < (tdc_bfhp_pkg::CHAN_W + 1)'(NUM_CHANNELS));

	// Keep only the first hit of a channel: write the time when the flag is clear.
	assign mem_we = word_take && (kind == tdc_bfhp_pkg::KIND_MEAS) && meas_in_range
		&& !hit_seen_q[meas_ch[CH_W-1:0]];

	assign end_kind  = (kind == tdc_bfhp_pkg::KIND_OBTRL) || (kind == tdc_bfhp_pkg::KIND_FILL);
	// The word that brings the count to MAX_WORDS ends the block.
	assign end_limit = (words_q == WORDS_W'(MAX_WORDS - 1));
	assign block_end = word_take && (end_kind || end_limit);

	// Output register frees when empty or when its word is taken this cycle.
	assign out_free   = !result_valid_q || !result_stall;
	// Issue the next channel read when the read stage is empty or moving on.
	assign issue      = (state_q == tdc_bfhp_pkg::ST_DRAIN) && (!valid_s1 || out_free);
	assign drain_last = (drain_ch_q == CH_W'(NUM_CHANNELS - 1));

	// ------------------------------------------------------------------
	// Block state and sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tdc_bfhp_pkg::ST_ACCEPT;
			hit_seen_q <= '0;
			event_q    <= '0;
			error_q    <= '0;
			words_q    <= '0;
			drain_ch_q <= '0;
		end else begin
			unique case (state_q)
				tdc_bfhp_pkg::ST_ACCEPT: begin
					if (word_take) begin
						words_q <= words_q + 1'b1;
						if (kind == tdc_bfhp_pkg::KIND_GHEAD) begin
							event_q <= word[26:5];
						end
						if (kind == tdc_bfhp_pkg::KIND_ERROR) begin
							error_q <= error_q | word[13:0];
						end
						if (mem_we) begin
							hit_seen_q[meas_ch[CH_W-1:0]] <= 1'b1;
						end
						// Block complete: start draining from channel zero.
						if (block_end) begin
							state_q    <= tdc_bfhp_pkg::ST_DRAIN;
							drain_ch_q <= '0;
						end
					end
				end
				tdc_bfhp_pkg::ST_DRAIN: begin
					if (issue) begin
						if (drain_last) begin
							// Last channel is in flight with its snapshot: clear the block.
							state_q    <= tdc_bfhp_pkg::ST_ACCEPT;
							hit_seen_q <= '0;
							event_q    <= '0;
							error_q    <= '0;
							words_q    <= '0;
							drain_ch_q <= '0;
						end else begin
							drain_ch_q <= drain_ch_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= tdc_bfhp_pkg::ST_ACCEPT;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// First-time memory: write while collecting, read while draining.
	// Read data holds until the next issue, so it doubles as the skid slot.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			first_time_mem[meas_ch[CH_W-1:0]] <= word[20:0];
		end
		if (issue) begin
			rd_data_s1 <= first_time_mem[drain_ch_q];
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload: capture the flag and block snapshot with the read.
	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1    <= drain_ch_q;
			hit_s1   <= hit_seen_q[drain_ch_q];
			last_s1  <= drain_last;
			event_s1 <= event_q;
			error_s1 <= error_q;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			channel_q      <= tdc_bfhp_pkg::CHAN_W'(ch_s1);
			hit_q          <= hit_s1;
			// Report zero time for a channel without a hit.
			hit_time_q     <= hit_s1 ? rd_data_s1 : '0;
			event_number_q <= event_s1;
			error_bits_q   <= error_s1;
			last_q         <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign channel      = channel_q;
	assign hit          = hit_q;
	assign hit_time     = hit_time_q;
	assign event_number = event_number_q;
	assign error_bits   = error_bits_q;
	assign last         = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// While collecting, the word count stays below the limit: the limit word
	// always ends the block.
	a_words_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdc_bfhp_pkg::ST_ACCEPT) |-> (words_q < WORDS_W'(MAX_WORDS)))
		else $error("word count reached MAX_WORDS without ending the block");

	// Held read data must not change while the read stage waits on the output.
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> $stable(rd_data_s1) && valid_s1)
		else $error("read stage data lost while output stalled");

	// Issuing the last channel returns to collecting with the block cleared.
	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && drain_last) |=> (state_q == tdc_bfhp_pkg::ST_ACCEPT) && (hit_seen_q == '0)
			&& (words_q == '0) && (error_q == '0) && (event_q == '0))
		else $error("block state not cleared after drain");

	// A block end always starts the drain at channel zero.
	a_end_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		block_end |=> (state_q == tdc_bfhp_pkg::ST_DRAIN) && (drain_ch_q == '0))
		else $error("block end did not start the drain");

	// The output shows a last mark only for the top channel.
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> (channel == tdc_bfhp_pkg::CHAN_W'(NUM_CHANNELS - 1)))
		else $error("last mark on a channel other than the top one");

endmodule
